FILE: hdl/wlfjo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlfjo_pkg
// Shared types and constants for the worker load fork/join oracle.
// ----------------------------------------------------------------------------
package wlfjo_pkg;

  localparam int unsigned TableDepthDefault = 16;
  localparam int unsigned LoadBitsDefault   = 32;
  localparam int unsigned RankBits          = 16;
  localparam int unsigned StabBits          = 8;
  localparam int unsigned CfgIndexBits      = 2;

  typedef enum logic [1:0] {
    CMD_REPORT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_FAILED = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    DEC_CONTINUE    = 2'd0,
    DEC_FORK_GREEDY = 2'd1,
    DEC_FORK_ONCE   = 2'd2,
    DEC_JOIN        = 2'd3
  } dec_t;

  typedef enum logic [1:0] {
    REG_JOINS_ALLOWED = 2'd0,
    REG_GLOBAL_MASTER = 2'd1,
    REG_CELL_LIMIT    = 2'd2,
    REG_MIN_STAB      = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_MUL,
    ST_DECIDE,
    ST_WRITE
  } state_t;

endpackage

FILE: hdl/wlfjo_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlfjo_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface wlfjo_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/worker_load_fork_join_oracle_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worker_load_fork_join_oracle_unit
// Worker load table held in a ring of cells, with fork/join decisions.
//
//  channel | dir | payload
//  in_ch   | in  | command, rank, three loads, worker_count, three flags
//  out_ch  | out | decision, table_cleared
//  cfg_ch  | in  | index (2 bits), data (32 bits)
//
// Every command rotates the ring once through all TableDepth cells (one
// cell a cycle), gathering sums and finding the rank; the ring is back in
// its original order when the rotation completes. Each command then runs
// the scan, one sum step, three multiply steps, one compare step and the
// write-back step. A write or an erase lands in the cells during the
// following idle cycle. One item is in flight at a time. Reset brings
// the state, strobes, count, fork-failed mark, output valid and config
// registers to their start values; the cells need no clearing. A query
// holds in its write-back step until the output register is free.
// ----------------------------------------------------------------------------
module worker_load_fork_join_oracle_unit
  import wlfjo_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDefault,
  parameter int unsigned LoadBits   = LoadBitsDefault
) (
  input logic clk,
  input logic rst,
  wlfjo_if.sink   in_ch,
  wlfjo_if.source out_ch,
  wlfjo_if.sink   cfg_ch
);

  localparam int unsigned IdxBits = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntBits = $clog2(TableDepth + 1);
  localparam int unsigned SumBits = LoadBits + CntBits + 1;
  localparam int unsigned ProdBits = SumBits + CntBits + 4;
  localparam int unsigned CmpBits = ((LoadBits > 32) ? LoadBits : 32) + 4;

  // ---------------- configuration ----------------
  logic        joins_allowed, is_global_master;
  logic [31:0] cell_limit;
  logic [7:0]  stab_threshold;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      joins_allowed    <= 1'b1;
      is_global_master <= 1'b0;
      cell_limit       <= 32'd100;
      stab_threshold   <= 8'd4;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.payload.index))
        REG_JOINS_ALLOWED: joins_allowed    <= cfg_ch.payload.data[0];
        REG_GLOBAL_MASTER: is_global_master <= cfg_ch.payload.data[0];
        REG_CELL_LIMIT:    cell_limit       <= cfg_ch.payload.data;
        REG_MIN_STAB:      stab_threshold   <= cfg_ch.payload.data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- cell chain ----------------
  logic [RankBits-1:0] c_rank   [TableDepth];
  logic [LoadBits-1:0] c_local  [TableDepth];
  logic [LoadBits-1:0] c_total  [TableDepth];
  logic [LoadBits-1:0] c_plocal [TableDepth];
  logic [StabBits-1:0] c_stab   [TableDepth];
  logic                c_mark   [TableDepth];

  logic                shift_en, del_en, wr_en;
  logic [IdxBits-1:0]  del_from;
  logic [RankBits-1:0] w_rank;
  logic [LoadBits-1:0] w_local, w_total, w_plocal;
  logic [StabBits-1:0] w_stab;
  logic                w_mark;
  logic [IdxBits-1:0]  w_idx;

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    localparam int unsigned Nb = (g + 1) % TableDepth;
    wlfjo_cell #(.LoadBits(LoadBits)) u_cell (
      .clk         (clk),
      .shift_en    (shift_en),
      .del_en      (del_en && (IdxBits'(g) >= del_from)),
      .wr_en       (wr_en && (w_idx == IdxBits'(g))),
      .nb_rank     (c_rank[Nb]),
      .nb_local    (c_local[Nb]),
      .nb_total    (c_total[Nb]),
      .nb_plocal   (c_plocal[Nb]),
      .nb_stab     (c_stab[Nb]),
      .nb_mark     (c_mark[Nb]),
      .wr_rank     (w_rank),
      .wr_local    (w_local),
      .wr_total    (w_total),
      .wr_plocal   (w_plocal),
      .wr_stab     (w_stab),
      .wr_mark     (w_mark),
      .rank        (c_rank[g]),
      .local_load  (c_local[g]),
      .total_load  (c_total[g]),
      .parent_local(c_plocal[g]),
      .stab        (c_stab[g]),
      .mark        (c_mark[g])
    );
  end

  // ---------------- control ----------------
  state_t state, state_next;
  logic [CntBits-1:0] count;
  logic               ffail;
  logic [CntBits-1:0] step;
  logic [IdxBits-1:0] found_idx;
  logic               found;
  logic [SumBits-1:0] sum_local, sum_total, extra;
  logic [LoadBits-1:0] master, first_local, first_total;
  logic               first_eq;

  // captured item
  cmd_t                cmd;
  logic [RankBits-1:0] q_rank;
  logic [LoadBits-1:0] q_local, q_total, q_plocal;
  logic [15:0]         q_wcount;
  logic                q_fork, q_join, q_bal;

  // working values of the found entry
  logic [LoadBits-1:0] fl, ft;
  logic [StabBits-1:0] fstab;
  logic                fmark;

  // multiply stage results
  logic [2:0]          mstep;
  logic [ProdBits-1:0] p_tn, p_ln, p_jn;
  logic [ProdBits-1:0] mul_a;
  logic [CntBits:0]    nd;
  logic [ProdBits-1:0] mul_p;

  // output register
  logic       out_valid;
  dec_t       out_dec;
  logic       out_clr;
  logic       out_free, write_go;

  assign in_ch.ready       = (state == ST_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.payload.decision      = out_dec;
  assign out_ch.payload.table_cleared = out_clr;

  // a query may only write back once the previous result has left
  assign out_free = !out_valid || out_ch.ready;
  assign write_go = (state == ST_WRITE) && ((cmd != CMD_QUERY) || out_free);

  assign nd    = {1'b0, count} + 1'b1;
  assign mul_p = mul_a * ProdBits'(nd);

  always_comb begin
    mul_a = '0;
    case (mstep)
      3'd0: mul_a = ProdBits'(ft);
      3'd1: mul_a = ProdBits'(fl);
      3'd2: mul_a = ProdBits'(master) + ProdBits'(extra) + ProdBits'(fl);
      default: mul_a = '0;
    endcase
  end

  logic head_hit;
  assign head_hit = ({1'b0, step} < {1'b0, count}) && (c_rank[0] == q_rank);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_ch.valid && in_ch.ready) begin
        state_next = ST_SCAN;
      end
      ST_SCAN:   if (step == CntBits'(TableDepth - 1)) begin
        state_next = ST_CALC;
      end
      ST_CALC:   state_next = ST_MUL;
      ST_MUL:    if (mstep == 3'd2) begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: state_next = ST_WRITE;
      ST_WRITE:  if (write_go) begin
        state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // decision logic from registered products
  logic [CmpBits-1:0] l9, c10;
  assign l9  = CmpBits'(fl) * CmpBits'(9);
  assign c10 = CmpBits'(cell_limit) * CmpBits'(10);

  dec_t dec_raw;
  logic gt_local;
  always_comb begin
    gt_local = p_ln > ProdBits'(sum_local);
    dec_raw  = DEC_CONTINUE;
    if (p_tn >= ProdBits'(sum_total)) begin
      if (gt_local && (CmpBits'(fl) > c10)) dec_raw = DEC_FORK_GREEDY;
    end else if (gt_local || (fl == ft)) begin
      if (l9 > c10) dec_raw = DEC_FORK_ONCE;
    end else if (p_jn < ProdBits'(sum_local)) begin
      dec_raw = DEC_JOIN;
    end
    if (CmpBits'(fl) < CmpBits'(cell_limit)) begin
      dec_raw = DEC_JOIN;
    end
  end

  // query outcome and table side effects
  dec_t q_dec;
  logic q_clr, q_setm, q_zstab;
  always_comb begin
    q_dec   = DEC_CONTINUE;
    q_clr   = 1'b0;
    q_setm  = 1'b0;
    q_zstab = 1'b0;
    if (q_wcount < 16'(count)) begin
      q_clr = 1'b1;
    end else if (q_wcount == 16'(count)) begin
      if (found && fstab >= stab_threshold) q_dec = dec_raw;
      else if (!found) q_clr = 1'b1;
      if (found) begin
        if (!q_bal) begin
          q_dec   = DEC_CONTINUE;
          q_zstab = 1'b1;
        end
        if (q_dec == DEC_JOIN) begin
          if (q_join && joins_allowed) q_setm = 1'b1;
          else q_dec = DEC_CONTINUE;
        end else if (q_dec == DEC_FORK_GREEDY) begin
          if (!q_fork || ffail) q_dec = DEC_CONTINUE;
          else q_setm = 1'b1;
        end
      end
    end
    if (is_global_master) begin
      q_dec = DEC_CONTINUE;
      if (q_fork && !ffail && !q_clr && count != '0 && q_bal && first_eq)
        q_dec = DEC_FORK_GREEDY;
    end
  end

  logic rpt_del, rpt_upd, rpt_new;
  assign rpt_del = found && fmark;
  assign rpt_upd = found && !fmark;
  assign rpt_new = !found && ({1'b0, count} < (CntBits+1)'(TableDepth));

  // registered strobes into the cell chain; erase and write are one-cycle strobes, shift is held for the rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_en <= 1'b0;
      del_en   <= 1'b0;
      wr_en    <= 1'b0;
    end else begin
      shift_en <= ((state == ST_IDLE) && in_ch.valid) ||
                  ((state == ST_SCAN) && (step != CntBits'(TableDepth - 1)));
      del_en   <= write_go && (cmd == CMD_REPORT) && rpt_del;
      wr_en    <= write_go && (((cmd == CMD_REPORT) && (rpt_upd || rpt_new)) ||
                               ((cmd == CMD_QUERY) && (q_setm || q_zstab)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ffail     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (write_go && (cmd == CMD_QUERY)) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          cmd       <= cmd_t'(in_ch.payload.command);
          q_rank    <= in_ch.payload.worker_rank;
          q_local   <= LoadBits'(in_ch.payload.local_workload);
          q_total   <= LoadBits'(in_ch.payload.total_workload);
          q_plocal  <= LoadBits'(in_ch.payload.parent_local_workload);
          q_wcount  <= in_ch.payload.worker_count;
          q_fork    <= in_ch.payload.fork_allowed;
          q_join    <= in_ch.payload.join_allowed;
          q_bal     <= in_ch.payload.grid_balanced;
          step      <= '0;
          found     <= 1'b0;
          found_idx <= '0;
          sum_local <= '0;
          sum_total <= '0;
          extra     <= '0;
        end
        ST_SCAN: begin
          // head cell holds entry 'step' this cycle
          if (step == '0) begin
            master      <= c_plocal[0];
            first_local <= c_local[0];
            first_total <= c_total[0];
          end
          if ({1'b0, step} < {1'b0, count}) begin
            sum_local <= sum_local + SumBits'(c_local[0]);
            sum_total <= sum_total + SumBits'(c_total[0]);
            if (c_mark[0]) extra <= extra + SumBits'(c_local[0]);
          end
          if (head_hit && !found) begin
            found     <= 1'b1;
            found_idx <= IdxBits'(step);
            fl        <= c_local[0];
            ft        <= c_total[0];
            fstab     <= c_stab[0];
            fmark     <= c_mark[0];
          end
          step <= step + 1'b1;
          mstep <= '0;
        end
        ST_CALC: begin
          if (count == '0) master <= '0;
          first_eq  <= (first_local == first_total);
          sum_local <= sum_local + SumBits'((count == '0) ? '0 : master);
        end
        ST_MUL: begin
          case (mstep)
            3'd0: p_tn <= mul_p;
            3'd1: p_ln <= mul_p;
            default: p_jn <= mul_p;
          endcase
          mstep <= mstep + 1'b1;
        end
        ST_DECIDE: begin
          // idle cycle for the compare path
        end
        ST_WRITE: if (write_go) begin
          case (cmd)
            CMD_REPORT: begin
              w_rank   <= q_rank;
              w_local  <= q_local;
              w_total  <= q_total;
              w_plocal <= q_plocal;
              w_mark   <= found ? fmark : 1'b0;
              if (rpt_del) begin
                del_from <= found_idx;
                count    <= count - 1'b1;
              end else if (rpt_upd) begin
                w_idx <= found_idx;
                if (q_local != fl || q_total != ft) w_stab <= '0;
                else if (fstab != '1) w_stab <= fstab + 1'b1;
                else w_stab <= fstab;
              end else if (rpt_new) begin
                w_idx <= IdxBits'(count);
                w_stab <= (q_local == '0 && q_total == '0) ? StabBits'(1) : '0;
                count <= count + 1'b1;
              end
            end
            CMD_QUERY: begin
              if (q_clr) count <= '0;
              if (q_setm || q_zstab) begin
                w_idx    <= found_idx;
                w_rank   <= q_rank;
                w_local  <= fl;
                w_total  <= ft;
                w_plocal <= c_plocal[found_idx];
                w_stab   <= q_zstab ? '0 : fstab;
                w_mark   <= q_setm ? 1'b1 : fmark;
              end
              ffail   <= 1'b0;
              out_dec <= q_dec;
              out_clr <= q_clr;
            end
            CMD_FAILED: ffail <= 1'b1;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/wlfjo_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlfjo_cell
// One table entry. Shifts its contents toward the head of the chain each
// scan cycle (rotation), and takes a write or a delete-shift from the
// controller.
// ----------------------------------------------------------------------------
module wlfjo_cell
  import wlfjo_pkg::*;
#(
  parameter int unsigned LoadBits = LoadBitsDefault
) (
  input  logic                clk,
  input  logic                shift_en,   // rotate: take neighbor's entry
  input  logic                del_en,     // take neighbor's entry (erase)
  input  logic                wr_en,      // write this entry
  input  logic [RankBits-1:0] nb_rank,
  input  logic [LoadBits-1:0] nb_local,
  input  logic [LoadBits-1:0] nb_total,
  input  logic [LoadBits-1:0] nb_plocal,
  input  logic [StabBits-1:0] nb_stab,
  input  logic                nb_mark,
  input  logic [RankBits-1:0] wr_rank,
  input  logic [LoadBits-1:0] wr_local,
  input  logic [LoadBits-1:0] wr_total,
  input  logic [LoadBits-1:0] wr_plocal,
  input  logic [StabBits-1:0] wr_stab,
  input  logic                wr_mark,
  output logic [RankBits-1:0] rank,
  output logic [LoadBits-1:0] local_load,
  output logic [LoadBits-1:0] total_load,
  output logic [LoadBits-1:0] parent_local,
  output logic [StabBits-1:0] stab,
  output logic                mark
);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rank         <= wr_rank;
      local_load   <= wr_local;
      total_load   <= wr_total;
      parent_local <= wr_plocal;
      stab         <= wr_stab;
      mark         <= wr_mark;
    end else if (shift_en || del_en) begin
      rank         <= nb_rank;
      local_load   <= nb_local;
      total_load   <= nb_total;
      parent_local <= nb_plocal;
      stab         <= nb_stab;
      mark         <= nb_mark;
    end
  end

endmodule

FILE: hdl/wlfjo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlfjo_checker
// Port-level checks on the oracle's handshakes.
// ----------------------------------------------------------------------------
module wlfjo_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_decision
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_decision))
    else $error("result dropped while stalled");

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("took a second item while busy");

  a_out_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(out_decision))
    else $error("result shown with an unknown decision");

endmodule

bind worker_load_fork_join_oracle_unit wlfjo_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_decision(out_ch.payload.decision)
);
